### hdl/bpra_pkg.sv
`default_nettype none
package bpra_pkg;
    localparam logic [2:0] CMD_RESERVE = 3'd0;
    localparam logic [2:0] CMD_UNDO    = 3'd1;
    localparam logic [2:0] CMD_CHECK   = 3'd2;
    localparam logic [2:0] CMD_ADD     = 3'd3;
    localparam logic [2:0] CMD_SUB     = 3'd4;
    localparam logic [2:0] CMD_REMOVE  = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOMEM    = 2'd1;
    localparam logic [1:0] ST_NOPAIR   = 2'd2;
    localparam logic [1:0] ST_NOSTREAM = 2'd3;

    localparam logic [1:0] REG_POOL  = 2'd0;
    localparam logic [1:0] REG_LFRAC = 2'd1;
    localparam logic [1:0] REG_FLOOR = 2'd2;
    localparam logic [1:0] REG_HFRAC = 2'd3;

    localparam int FRAC_W = 17;
endpackage
`default_nettype wire

### hdl/buffer_pool_reservation_admission.sv
`default_nettype none
// channel | handshake        | payload
// in      | in_valid/in_stall  | command, stream_id, producer_id, amount
// out     | out_valid/out_stall| status, stream_used_now, total_used_now,
//         |                    | total_reserved_now
// cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data
// Each item passes S_READ (memory read, product start), S_MUL, S_EXEC (compare and
// write back); stream and pair memories see one read, at most one write per item.
// After reset a clearing pass over all PAIRS entries zeroes the pair memory;
// in_stall holds high until it is done.
// A result waits in the output register; the next item is taken once it is
// out or while it is being taken.
module buffer_pool_reservation_admission #(
    parameter int STREAMS = 64,
    parameter int PRODUCERS = 8,
    parameter int SIZE_BITS = 40
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [2:0]            command,
    input  wire logic [((STREAMS > 1) ? $clog2(STREAMS) : 1)-1:0] stream_id,
    input  wire logic [((PRODUCERS > 1) ? $clog2(PRODUCERS) : 1)-1:0] producer_id,
    input  wire logic [SIZE_BITS-1:0]  amount,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [1:0]                 status,
    output logic [SIZE_BITS-1:0]       stream_used_now,
    output logic [SIZE_BITS-1:0]       total_used_now,
    output logic [SIZE_BITS-1:0]       total_reserved_now,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [63:0]           cfg_data
);
    import bpra_pkg::*;
    localparam int SW = (STREAMS > 1) ? $clog2(STREAMS) : 1;
    localparam int PRW = (PRODUCERS > 1) ? $clog2(PRODUCERS) : 1;
    localparam int PAIRS = STREAMS * PRODUCERS;
    localparam int AW = $clog2(PAIRS) > 0 ? $clog2(PAIRS) : 1;
    localparam int W = SIZE_BITS;
    localparam int PW = W + FRAC_W;
    localparam int CW = W + 18;
    localparam logic [W-1:0] MAXV = {W{1'b1}};
    localparam logic [1:0] S_IDLE = 2'd0, S_READ = 2'd1, S_MUL = 2'd2, S_EXEC = 2'd3;

    logic [1:0] state_reg;
    logic [2:0] cmd_reg;
    logic [SW-1:0] sid_reg;
    logic [AW-1:0] pidx_reg;
    logic [W-1:0] amt_reg;
    logic bad_reg;

    logic [STREAMS-1:0] sp_reg;
    logic [2*W-1:0] smem [STREAMS];
    // pair entry: presence in the top bit, usage below
    logic [W:0] pmem [PAIRS];
    logic [2*W-1:0] srd_reg;
    logic [W:0] prd_reg;
    logic clr_reg;
    logic [AW-1:0] clr_idx_reg;

    logic [W-1:0] used_total_reg, reserved_total_reg;
    logic [W-1:0] pool_reg, floor_reg;
    logic [FRAC_W-1:0] lfrac_reg, hfrac_reg;

    logic out_valid_reg;
    logic [1:0] st_reg;
    logic [W-1:0] sun_reg, tun_reg, trn_reg;

    logic [PW-1:0] lim_p, head_p;
    logic mul_go;

    assign cfg_ready = (state_reg == S_IDLE);
    assign in_stall = clr_reg || (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign out_valid = out_valid_reg;
    assign status = st_reg;
    assign stream_used_now = sun_reg;
    assign total_used_now = tun_reg;
    assign total_reserved_now = trn_reg;
    assign mul_go = (state_reg == S_READ);

    bpra_mul #(.SIZE_BITS(W)) u_lim (.clk(clk), .start(mul_go), .a(pool_reg),
        .b(lfrac_reg), .p(lim_p));
    bpra_mul #(.SIZE_BITS(W)) u_head (.clk(clk), .start(mul_go), .a(pool_reg),
        .b(hfrac_reg), .p(head_p));

    function automatic logic [W-1:0] sadd(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[W] ? MAXV : s[W-1:0];
    endfunction

    function automatic logic [W-1:0] ssub(input logic [W-1:0] a, input logic [W-1:0] b);
        return (a > b) ? a - b : '0;
    endfunction

    // Execute stage
    logic [SW-1:0] s;
    logic [AW-1:0] p;
    logic spres, ppres;
    logic [W-1:0] resv, used, pu, room, diff, remaining, base;
    logic [CW-1:0] lhs, rhs;
    logic do_add;
    logic sp_n, pp_n, sw_en, pw_en;
    logic [W-1:0] resv_n, used_n, pu_n, ut_n, rt_n;
    logic [1:0] st_n;

    always_comb
    begin
        s = sid_reg;
        p = pidx_reg;
        spres = sp_reg[s];
        ppres = prd_reg[W];
        resv = srd_reg[2*W-1:W];
        used = srd_reg[W-1:0];
        pu = prd_reg[W-1:0];
        room = ssub(pool_reg, reserved_total_reg);
        diff = amt_reg - resv;
        remaining = resv - ((resv < used) ? resv : used);
        base = (used_total_reg > reserved_total_reg) ? used_total_reg : reserved_total_reg;
        lhs = CW'({1'b0, base} + {1'b0, amt_reg}) << 16;
        rhs = (CW'(remaining) << 16) + CW'(head_p);
        do_add = 1'b0;
        sp_n = spres;
        pp_n = ppres;
        resv_n = resv;
        used_n = used;
        pu_n = pu;
        ut_n = used_total_reg;
        rt_n = reserved_total_reg;
        st_n = ST_OK;
        case (cmd_reg)
            CMD_RESERVE:
            begin
                if (!spres)
                begin
                    if (room >= amt_reg)
                    begin
                        rt_n = sadd(reserved_total_reg, amt_reg);
                        sp_n = 1'b1;
                        resv_n = amt_reg;
                        used_n = '0;
                    end
                    else
                        st_n = ST_NOMEM;
                end
                else if (amt_reg > resv)
                begin
                    if (room >= diff)
                    begin
                        rt_n = sadd(reserved_total_reg, diff);
                        resv_n = amt_reg;
                    end
                    else
                        st_n = ST_NOMEM;
                end
            end
            CMD_UNDO:
            begin
                if (spres)
                begin
                    rt_n = ssub(reserved_total_reg, resv);
                    sp_n = 1'b0;
                end
            end
            CMD_CHECK:
            begin
                if (!spres)
                    st_n = ST_NOSTREAM;
                else if (used > floor_reg && ({1'b0, used, 16'd0} > lim_p))
                    st_n = ST_NOMEM;
                else if (lhs > rhs)
                    st_n = ST_NOMEM;
                else
                    do_add = 1'b1;
            end
            CMD_ADD: do_add = 1'b1;
            CMD_SUB:
            begin
                if (spres)
                    used_n = ssub(used, amt_reg);
                if (!ppres)
                    st_n = ST_NOPAIR;
                else
                begin
                    if (pu > amt_reg)
                        pu_n = pu - amt_reg;
                    else
                        pp_n = 1'b0;
                    ut_n = ssub(used_total_reg, amt_reg);
                end
            end
            CMD_REMOVE:
            begin
                if (ppres)
                    pp_n = 1'b0;
                else
                    st_n = ST_NOPAIR;
            end
            default: ;
        endcase
        if (do_add)
        begin
            if (spres)
                used_n = sadd(used, amt_reg);
            pu_n = ppres ? sadd(pu, amt_reg) : amt_reg;
            pp_n = 1'b1;
            ut_n = sadd(used_total_reg, amt_reg);
        end
        if (bad_reg)
        begin
            st_n = ST_NOSTREAM;
            sp_n = spres;
            pp_n = ppres;
            ut_n = used_total_reg;
            rt_n = reserved_total_reg;
        end
        sw_en = (state_reg == S_EXEC) && !bad_reg;
        pw_en = sw_en;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid && !in_stall)
        begin
            cmd_reg <= command;
            sid_reg <= stream_id;
            pidx_reg <= AW'(stream_id) * AW'(PRODUCERS) + AW'(producer_id);
            amt_reg <= amount;
            bad_reg <= (32'(stream_id) >= STREAMS) || (32'(producer_id) >= PRODUCERS);
        end
        if (state_reg == S_READ)
        begin
            srd_reg <= smem[sid_reg];
            prd_reg <= pmem[pidx_reg];
        end
        if (sw_en)
            smem[s] <= {resv_n, used_n};
        if (clr_reg)
            pmem[clr_idx_reg] <= '0;
        else if (pw_en)
            pmem[p] <= {pp_n, pu_n};
        if (state_reg == S_EXEC)
        begin
            st_reg <= st_n;
            sun_reg <= (!bad_reg && sp_n) ? used_n : '0;
            tun_reg <= ut_n;
            trn_reg <= rt_n;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            sp_reg <= '0;
            clr_reg <= 1'b1;
            clr_idx_reg <= '0;
            used_total_reg <= '0;
            reserved_total_reg <= '0;
            pool_reg <= '0;
            floor_reg <= '0;
            lfrac_reg <= 17'd65536;
            hfrac_reg <= 17'd65536;
        end
        else
        begin
            if (clr_reg)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
                if (clr_idx_reg == AW'(PAIRS - 1))
                    clr_reg <= 1'b0;
            end
            if (state_reg == S_EXEC)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_POOL:  pool_reg <= cfg_data[W-1:0];
                    REG_LFRAC: lfrac_reg <= cfg_data[FRAC_W-1:0];
                    REG_FLOOR: floor_reg <= cfg_data[W-1:0];
                    REG_HFRAC: hfrac_reg <= cfg_data[FRAC_W-1:0];
                    default: ;
                endcase
            end
            case (state_reg)
                S_IDLE: if (in_valid && !in_stall) state_reg <= S_READ;
                S_READ: state_reg <= S_MUL;
                S_MUL:  state_reg <= S_EXEC;
                S_EXEC:
                begin
                    state_reg <= S_IDLE;
                    if (!bad_reg)
                        sp_reg[s] <= sp_n;
                    used_total_reg <= ut_n;
                    reserved_total_reg <= rt_n;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### hdl/bpra_mul.sv
`default_nettype none
// Unsigned product of a SIZE_BITS operand and a 17-bit fraction, split into
// two halves so each multiplier stays narrow; low half registers on start.
module bpra_mul #(
    parameter int SIZE_BITS = 40
) (
    input  wire logic                          clk,
    input  wire logic                          start,
    input  wire logic [SIZE_BITS-1:0]          a,
    input  wire logic [bpra_pkg::FRAC_W-1:0]   b,
    output logic [SIZE_BITS+bpra_pkg::FRAC_W-1:0] p
);
    import bpra_pkg::*;
    localparam int LO_W = SIZE_BITS / 2;
    localparam int HI_W = SIZE_BITS - LO_W;
    localparam int PW = SIZE_BITS + FRAC_W;

    logic [HI_W-1:0] hi_reg;
    logic [FRAC_W-1:0] b_reg;
    logic [LO_W+FRAC_W-1:0] lo_prod_reg;
    logic [HI_W+FRAC_W-1:0] hi_prod;

    assign hi_prod = hi_reg * b_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            lo_prod_reg <= a[LO_W-1:0] * b;
            hi_reg <= a[SIZE_BITS-1:LO_W];
            b_reg <= b;
        end
    end

    assign p = PW'(lo_prod_reg) + (PW'(hi_prod) << LO_W);
endmodule
`default_nettype wire

### hdl/bpra_checker.sv
`default_nettype none
module bpra_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [1:0]  status,
    input wire logic [39:0] total_used_now
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(total_used_now))
        else $error("stalled result changed");
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !out_valid || $past(out_valid))
        else $error("result too early");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second beat taken while busy");
    a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result during reset");
endmodule

bind buffer_pool_reservation_admission bpra_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .total_used_now(total_used_now));
`default_nettype wire

### tb/sv/tb_buffer_pool_reservation_admission.sv
`default_nettype none
module tb_buffer_pool_reservation_admission;
    import bpra_pkg::*;

    localparam logic [39:0] MAXV = 40'hFF_FFFF_FFFF;
    localparam int STALL_LIMIT = 20000;
    // command codes with no operation behind them
    localparam logic [2:0] CMD_RSVD_6 = 3'd6;
    localparam logic [2:0] CMD_RSVD_7 = 3'd7;

    typedef struct packed {
        logic [1:0]  status;
        logic [39:0] stream_used;
        logic [39:0] total_used;
        logic [39:0] total_reserved;
    } acct_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  command;
    logic [5:0]  stream_id;
    logic [2:0]  producer_id;
    logic [39:0] amount;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [39:0] stream_used_now;
    logic [39:0] total_used_now;
    logic [39:0] total_reserved_now;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    buffer_pool_reservation_admission u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .stream_id(stream_id), .producer_id(producer_id),
        .amount(amount),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .stream_used_now(stream_used_now),
        .total_used_now(total_used_now), .total_reserved_now(total_reserved_now),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // pool accounting mirror
    logic        pool_stream_on [64];
    logic [39:0] pool_stream_resv [64];
    logic [39:0] pool_stream_used [64];
    logic        pool_pair_on [512];
    logic [39:0] pool_pair_usage [512];
    logic [39:0] pool_used_total;
    logic [39:0] pool_resv_total;
    logic [39:0] cfg_pool;
    logic [16:0] cfg_lfrac;
    logic [39:0] cfg_floor;
    logic [16:0] cfg_hfrac;

    acct_result_t pending_results[$];
    int errors;
    int idle_cycles;
    int burst_left;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [39:0] sat_plus(logic [39:0] a, logic [39:0] b);
        logic [40:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[40] ? MAXV : s[39:0];
    endfunction

    function automatic logic [39:0] sat_minus(logic [39:0] a, logic [39:0] b);
        return (a > b) ? a - b : 40'd0;
    endfunction

    function automatic acct_result_t account_step(logic [2:0] cmd, logic [5:0] sid,
                                                  logic [2:0] pid, logic [39:0] amt);
        acct_result_t r;
        int           p;
        logic         do_add;
        logic [39:0]  diff;
        logic [39:0]  used;
        logic [39:0]  resv;
        logic [39:0]  remaining;
        logic [39:0]  base;
        logic [63:0]  lhs;
        logic [63:0]  rhs;
        p = sid * 8 + pid;
        do_add = 1'b0;
        r.status = ST_OK;
        case (cmd)
            CMD_RESERVE:
            begin
                if (!pool_stream_on[sid])
                begin
                    if (sat_minus(cfg_pool, pool_resv_total) >= amt)
                    begin
                        pool_resv_total = sat_plus(pool_resv_total, amt);
                        pool_stream_on[sid] = 1'b1;
                        pool_stream_resv[sid] = amt;
                        pool_stream_used[sid] = '0;
                    end
                    else
                        r.status = ST_NOMEM;
                end
                else if (amt > pool_stream_resv[sid])
                begin
                    diff = amt - pool_stream_resv[sid];
                    if (sat_minus(cfg_pool, pool_resv_total) >= diff)
                    begin
                        pool_resv_total = sat_plus(pool_resv_total, diff);
                        pool_stream_resv[sid] = amt;
                    end
                    else
                        r.status = ST_NOMEM;
                end
            end
            CMD_UNDO:
            begin
                if (pool_stream_on[sid])
                begin
                    pool_resv_total = sat_minus(pool_resv_total, pool_stream_resv[sid]);
                    pool_stream_on[sid] = 1'b0;
                end
            end
            CMD_CHECK:
            begin
                if (!pool_stream_on[sid])
                    r.status = ST_NOSTREAM;
                else
                begin
                    used = pool_stream_used[sid];
                    resv = pool_stream_resv[sid];
                    if (used > cfg_floor &&
                        {8'd0, used, 16'd0} > 64'(cfg_pool) * 64'(cfg_lfrac))
                        r.status = ST_NOMEM;
                    else
                    begin
                        remaining = resv - ((resv < used) ? resv : used);
                        base = (pool_used_total > pool_resv_total) ? pool_used_total
                                                                  : pool_resv_total;
                        lhs = (64'(base) + 64'(amt)) << 16;
                        rhs = {8'd0, remaining, 16'd0} + 64'(cfg_pool) * 64'(cfg_hfrac);
                        if (lhs > rhs)
                            r.status = ST_NOMEM;
                        else
                            do_add = 1'b1;
                    end
                end
            end
            CMD_ADD: do_add = 1'b1;
            CMD_SUB:
            begin
                if (pool_stream_on[sid])
                    pool_stream_used[sid] = sat_minus(pool_stream_used[sid], amt);
                if (!pool_pair_on[p])
                    r.status = ST_NOPAIR;
                else
                begin
                    if (pool_pair_usage[p] > amt)
                        pool_pair_usage[p] = pool_pair_usage[p] - amt;
                    else
                        pool_pair_on[p] = 1'b0;
                    pool_used_total = sat_minus(pool_used_total, amt);
                end
            end
            CMD_REMOVE:
            begin
                if (pool_pair_on[p])
                    pool_pair_on[p] = 1'b0;
                else
                    r.status = ST_NOPAIR;
            end
            default: ;
        endcase
        if (do_add)
        begin
            if (pool_stream_on[sid])
                pool_stream_used[sid] = sat_plus(pool_stream_used[sid], amt);
            if (pool_pair_on[p])
                pool_pair_usage[p] = sat_plus(pool_pair_usage[p], amt);
            else
            begin
                pool_pair_on[p] = 1'b1;
                pool_pair_usage[p] = amt;
            end
            pool_used_total = sat_plus(pool_used_total, amt);
        end
        r.stream_used = pool_stream_on[sid] ? pool_stream_used[sid] : 40'd0;
        r.total_used = pool_used_total;
        r.total_reserved = pool_resv_total;
        return r;
    endfunction

    // valid stays high across a burst; drop it only for a gap or a drain
    task automatic send_command(logic [2:0] cmd, logic [5:0] sid, logic [2:0] pid,
                                logic [39:0] amt);
        int gap;
        acct_result_t exp_r;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 5);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        in_valid <= 1'b1;
        command <= cmd;
        stream_id <= sid;
        producer_id <= pid;
        amount <= amt;
        exp_r = account_step(cmd, sid, pid, amt);
        pending_results = {pending_results, exp_r};
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_POOL:  cfg_pool = value[39:0];
            REG_LFRAC: cfg_lfrac = value[16:0];
            REG_FLOOR: cfg_floor = value[39:0];
            REG_HFRAC: cfg_hfrac = value[16:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic write_reg_idle(logic [1:0] idx, logic [63:0] value);
        drain_results();
        write_reg(idx, value);
    endtask

    function automatic logic [39:0] rand_amount();
        case ($urandom_range(0, 5))
            0: return 40'd0;
            1: return MAXV - 40'($urandom_range(0, 3));
            2: return 40'({$urandom(), $urandom()});
            default: return 40'($urandom_range(0, 4000));
        endcase
    endfunction

    task automatic test_directed();
        send_command(CMD_ADD, 6'd0, 3'd0, 40'd5);
        send_command(CMD_CHECK, 6'd0, 3'd0, 40'd1);
        send_command(CMD_RESERVE, 6'd1, 3'd0, 40'd1);
        write_reg_idle(REG_POOL, 64'hFFFF_FFFF_FFFF_FFFF);
        send_command(CMD_RESERVE, 6'd63, 3'd7, 40'd1000);
        send_command(CMD_RESERVE, 6'd63, 3'd7, 40'd500);
        send_command(CMD_RESERVE, 6'd63, 3'd7, 40'd2000);
        send_command(CMD_RESERVE, 6'd2, 3'd1, MAXV);
        send_command(CMD_CHECK, 6'd63, 3'd7, 40'd100);
        send_command(CMD_ADD, 6'd63, 3'd7, MAXV);
        send_command(CMD_ADD, 6'd63, 3'd7, 40'd10);
        send_command(CMD_CHECK, 6'd63, 3'd7, 40'd1);
        send_command(CMD_SUB, 6'd63, 3'd7, 40'd3);
        send_command(CMD_SUB, 6'd63, 3'd7, MAXV);
        send_command(CMD_SUB, 6'd63, 3'd6, 40'd3);
        send_command(CMD_ADD, 6'd5, 3'd2, 40'd7);
        send_command(CMD_REMOVE, 6'd5, 3'd2, 40'd0);
        send_command(CMD_REMOVE, 6'd5, 3'd2, 40'd0);
        send_command(CMD_UNDO, 6'd63, 3'd0, 40'd0);
        send_command(CMD_UNDO, 6'd63, 3'd0, 40'd0);
        send_command(CMD_RSVD_6, 6'd4, 3'd4, 40'd9);
        send_command(CMD_RSVD_7, 6'd4, 3'd4, 40'd9);
        drain_results();
    endtask

    // mostly reserve/check/add/sub cycles over the first n_streams streams, some noise
    task automatic test_random_phase(int n_items, int n_streams);
        logic [2:0]  cmd;
        logic [5:0]  sid;
        logic [39:0] amt;
        for (int i = 0; i < n_items; i++)
        begin
            sid = 6'($urandom_range(0, n_streams - 1));
            if ($urandom_range(0, 19) == 0)
                sid = 6'($urandom_range(0, 63));
            case ($urandom_range(0, 15))
                0, 1:    cmd = CMD_RESERVE;
                2:       cmd = CMD_UNDO;
                3, 4, 5, 6, 7: cmd = CMD_CHECK;
                8, 9:    cmd = CMD_ADD;
                10, 11, 12: cmd = CMD_SUB;
                13:      cmd = CMD_REMOVE;
                default: cmd = 3'($urandom_range(0, 7));
            endcase
            amt = rand_amount();
            if (cmd == CMD_RESERVE && $urandom_range(0, 1))
                amt = 40'($urandom_range(0, 60000));
            send_command(cmd, sid, 3'($urandom_range(0, 7)), amt);
        end
        drain_results();
    endtask

    task automatic test_config_sweep();
        write_reg_idle(REG_POOL, 64'd50000);
        write_reg(REG_LFRAC, 64'd16384);
        write_reg(REG_FLOOR, 64'd1000);
        write_reg(REG_HFRAC, 64'd32768);
        test_random_phase(350, 4);
        write_reg_idle(REG_LFRAC, 64'd0);
        write_reg(REG_FLOOR, 64'hFF_FFFF_FFFF);
        write_reg(REG_HFRAC, 64'd0);
        write_reg(REG_POOL, 64'd0);
        test_random_phase(200, 8);
        write_reg_idle(REG_POOL, 64'hFF_FFFF_FFFF);
        write_reg(REG_LFRAC, 64'd65536);
        write_reg(REG_FLOOR, 64'd0);
        write_reg(REG_HFRAC, 64'd65536);
        test_random_phase(300, 6);
        write_reg_idle(REG_POOL, {$urandom(), $urandom()});
        write_reg(REG_LFRAC, 64'($urandom_range(0, 65536)));
        write_reg(REG_FLOOR, 64'($urandom_range(0, 50000)));
        write_reg(REG_HFRAC, 64'($urandom_range(0, 65536)));
        test_random_phase(280, 64);
    endtask

    // receiver: stall in random free and busy stretches
    initial begin
        int run;
        out_stall = 1'b0;
        forever
        begin
            run = $urandom_range(1, 30);
            repeat (run) @(posedge clk);
            out_stall <= ($urandom_range(0, 2) == 0) ? 1'b0 : ($urandom_range(0, 1) == 1);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected beat: status=%0d", status);
                errors++;
            end
            else
            begin
                acct_result_t e;
                e = pending_results.pop_front();
                if (status !== e.status)
                begin
                    $error("status: expected %0d actual %0d", e.status, status);
                    errors++;
                end
                if (stream_used_now !== e.stream_used)
                begin
                    $error("stream_used_now: expected %0d actual %0d",
                           e.stream_used, stream_used_now);
                    errors++;
                end
                if (total_used_now !== e.total_used)
                begin
                    $error("total_used_now: expected %0d actual %0d",
                           e.total_used, total_used_now);
                    errors++;
                end
                if (total_reserved_now !== e.total_reserved)
                begin
                    $error("total_reserved_now: expected %0d actual %0d",
                           e.total_reserved, total_reserved_now);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        clk = 1'b0;
        errors = 0;
        idle_cycles = 0;
        burst_left = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        command = '0;
        stream_id = '0;
        producer_id = '0;
        amount = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        for (int i = 0; i < 64; i++)
        begin
            pool_stream_on[i] = 1'b0;
            pool_stream_resv[i] = '0;
            pool_stream_used[i] = '0;
        end
        for (int i = 0; i < 512; i++)
        begin
            pool_pair_on[i] = 1'b0;
            pool_pair_usage[i] = '0;
        end
        pool_used_total = '0;
        pool_resv_total = '0;
        cfg_pool = '0;
        cfg_lfrac = 17'd65536;
        cfg_floor = '0;
        cfg_hfrac = 17'd65536;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_config_sweep();
        drain_results();
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
`default_nettype wire
